// File: rtl/tank_level_pump_controller_defines.svh
// Assertion macros for the tank level pump controller.
`ifndef TANK_LEVEL_PUMP_CONTROLLER_DEFINES_SVH
`define TANK_LEVEL_PUMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TLPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TLPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tlpc_pkg.sv
// Types and constants shared by the tank level pump controller modules.
package tlpc_pkg;

	// Command codes of the input item.
	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_SET    = 3'd1;
	localparam logic [2:0] CMD_BUTTON = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_LOCK   = 3'd4;

	// Run status codes.
	localparam logic [1:0] STAT_IDLE    = 2'd0;
	localparam logic [1:0] STAT_RUN     = 2'd1;
	localparam logic [1:0] STAT_TIMEOUT = 2'd2;
	localparam logic [1:0] STAT_LOST    = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_HEIGHT  = 3'd0;
	localparam logic [2:0] REG_OFFSET  = 3'd1;
	localparam logic [2:0] REG_MIN     = 3'd2;
	localparam logic [2:0] REG_MAX     = 3'd3;
	localparam logic [2:0] REG_MAX_RT  = 3'd4;
	localparam logic [2:0] REG_AUTO    = 3'd5;

	// Configuration reset values.
	localparam logic [15:0] RST_HEIGHT = 16'd1200;
	localparam logic [15:0] RST_OFFSET = 16'd250;
	localparam logic [6:0]  RST_MIN    = 7'd25;
	localparam logic [6:0]  RST_MAX    = 7'd95;
	localparam logic [16:0] RST_MAX_RT = 17'd2700;
	localparam logic        RST_AUTO   = 1'b1;

	// Timing limits and fixed values.
	localparam logic [15:0] FRESH_LIMIT   = 16'd20;
	localparam logic [15:0] LOST_LIMIT    = 16'd120;
	localparam logic [16:0] RUN_SAT       = 17'h1FFFF;
	localparam logic [10:0] LEVEL_FULL    = 11'd1000;
	localparam logic [10:0] LEVEL_INVALID = 11'h7FF;
	localparam logic [27:0] LEVEL_SCALE   = 28'd2000;
	localparam int          DIV_STEPS     = 10;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_PREP,
		CS_DIV,
		CS_APPLY
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic div_step;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic div_last;
	} dp_stat_t;

endpackage

// File: rtl/tank_level_pump_controller.sv
// Top level of the tank level pump controller: sequencer, datapath and checks.
// A tick passes through capture, preparation, the ten-step restoring level divider and the
// state update before its result is registered; any other command skips the divider.
// A new item is taken only once the previous one has been applied; the update waits on out_stall.
// Reset (arst_n low, asynchronous): configuration to defaults, relay off, run status idle,
// level and runtime zero, link marked online, lock cleared, no result pending.
`include "tank_level_pump_controller_defines.svh"

module tank_level_pump_controller
	import tlpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port.
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	// Input channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic               value,
	input  logic               has_sample,
	input  logic [15:0]        sample_age_sec,
	input  logic [15:0]        distance_tenths_cm,
	input  logic               link_online,
	// Output channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic               pump_on,
	output logic [1:0]         status,
	output logic signed [10:0] level_tenths_pct,
	output logic [16:0]        runtime_sec,
	output logic               lock_active,
	output logic               sample_fresh
);

	// The sequencer and the datapath see each other only through these two groups.
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// The sequencer takes one transfer at a time. The result register sits in the
	// datapath, so a new item can be taken while the previous result still waits;
	// the state update of the new item holds back until that result is gone.
	tlpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// The datapath captures the item, works out the level for ticks with a
	// restoring divider (one quotient bit a cycle), then applies the command to
	// the relay, status, runtime, link and lock state in a single step.
	tlpc_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.cmd_in             (cmd),
		.value              (value),
		.has_sample         (has_sample),
		.sample_age_sec     (sample_age_sec),
		.distance_tenths_cm (distance_tenths_cm),
		.link_online        (link_online),
		.cmd                (dp_cmd),
		.stat               (dp_stat),
		.pump_on            (pump_on),
		.status             (status),
		.level_tenths_pct   (level_tenths_pct),
		.runtime_sec        (runtime_sec),
		.lock_active        (lock_active),
		.sample_fresh       (sample_fresh)
	);

	// Once an item is taken, no further transfer is taken in the next cycle.
	`TLPC_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall, "took two items back to back")

	// The divider runs its full count before the state update.
	`TLPC_ASSERT_NXT(a_div_runs_on, dp_cmd.div_step && !dp_stat.div_last, dp_cmd.div_step && !dp_cmd.apply, "divider stopped early")

	// A new result appears only right after a state update.
	`TLPC_ASSERT_IMP(a_result_from_apply, $rose(out_valid), $past(dp_cmd.apply), "result without update")

endmodule

// File: rtl/tlpc_ctrl.sv
// Sequencer of the tank level pump controller: handshakes and datapath commands.
module tlpc_ctrl
	import tlpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_n;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			CS_IDLE:  if (in_valid) state_n = CS_PREP;
			CS_PREP:  state_n = stat.is_tick ? CS_DIV : CS_APPLY;
			CS_DIV:   if (stat.div_last) state_n = CS_APPLY;
			CS_APPLY: if (out_free) state_n = CS_IDLE;
			default:  state_n = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture  = (state_q == CS_IDLE) && in_valid;
		cmd.prep     = (state_q == CS_PREP);
		cmd.div_step = (state_q == CS_DIV);
		cmd.apply    = (state_q == CS_APPLY) && out_free;
		in_stall     = (state_q != CS_IDLE);
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/tlpc_datapath.sv
// Datapath of the tank level pump controller: registers, level divider, state update.
module tlpc_datapath
	import tlpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic [2:0]         cmd_in,
	input  logic               value,
	input  logic               has_sample,
	input  logic [15:0]        sample_age_sec,
	input  logic [15:0]        distance_tenths_cm,
	input  logic               link_online,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic               pump_on,
	output logic [1:0]         status,
	output logic signed [10:0] level_tenths_pct,
	output logic [16:0]        runtime_sec,
	output logic               lock_active,
	output logic               sample_fresh
);

	// Configuration.
	logic [15:0] height_q, offset_q;
	logic [6:0]  min_q, max_q;
	logic [16:0] max_rt_q;
	logic        auto_q;

	// Captured item.
	logic [2:0]  cmd_q;
	logic        value_q, has_sample_q, online_q;
	logic [15:0] age_q, dist_q;

	// Divider and level class.
	logic [27:0] rem_q;
	logic [25:0] dsr_q;
	logic [9:0]  quo_q;
	logic [3:0]  cnt_q;
	logic        cls_inv_q, cls_full_q, cls_empty_q;

	// Controller state.
	logic        relay_q, was_online_q, lock_q;
	logic [1:0]  run_status_q;
	logic [10:0] level_q;
	logic [16:0] runtime_q;

	// Result registers.
	logic        o_pump_q, o_lock_q, o_fresh_q;
	logic [1:0]  o_status_q;
	logic [10:0] o_level_q;
	logic [16:0] o_runtime_q;

	logic [16:0] empty_w, diff_w;
	logic [27:0] num_w;
	logic        ge_w;
	logic [10:0] lvl_w;
	logic        fresh_w, snap_w;
	logic [10:0] min10_w, max10_w, lvl_cmp_w;

	logic        relay_n, was_n, lock_n, fresh_n;
	logic [1:0]  status_n;
	logic [10:0] level_n;
	logic [16:0] rt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= RST_HEIGHT;
			offset_q <= RST_OFFSET;
			min_q    <= RST_MIN;
			max_q    <= RST_MAX;
			max_rt_q <= RST_MAX_RT;
			auto_q   <= RST_AUTO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEIGHT: height_q <= cfg_data[15:0];
				REG_OFFSET: offset_q <= cfg_data[15:0];
				REG_MIN:    min_q    <= cfg_data[6:0];
				REG_MAX:    max_q    <= cfg_data[6:0];
				REG_MAX_RT: max_rt_q <= cfg_data;
				REG_AUTO:   auto_q   <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q        <= cmd_in;
			value_q      <= value;
			has_sample_q <= has_sample;
			age_q        <= sample_age_sec;
			dist_q       <= distance_tenths_cm;
			online_q     <= link_online;
		end
	end

	// Numerator 2000 * (empty - d) + h over divisor 2h, rounded half up.
	assign empty_w = {1'b0, offset_q} + {1'b0, height_q};
	assign diff_w  = empty_w - {1'b0, dist_q};
	assign num_w   = ({11'b0, diff_w} * LEVEL_SCALE) + {12'b0, height_q};
	assign ge_w    = rem_q >= {2'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q       <= num_w;
			dsr_q       <= {height_q, 10'b0};
			cls_inv_q   <= (dist_q == 16'd0);
			cls_full_q  <= (dist_q <= offset_q);
			cls_empty_q <= ({1'b0, dist_q} >= empty_w) || (height_q == 16'd0);
		end else if (cmd.div_step) begin
			if (ge_w) rem_q <= rem_q - {2'b0, dsr_q};
			quo_q <= {quo_q[8:0], ge_w};
			dsr_q <= dsr_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.prep) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	assign stat.is_tick  = (cmd_q == CMD_TICK);
	assign stat.div_last = (cnt_q == 4'(DIV_STEPS - 1));

	always_comb begin
		priority if (cls_inv_q) begin
			lvl_w = LEVEL_INVALID;
		end else if (cls_full_q) begin
			lvl_w = LEVEL_FULL;
		end else if (cls_empty_q) begin
			lvl_w = 11'd0;
		end else if ({1'b0, quo_q} > LEVEL_FULL) begin
			lvl_w = LEVEL_FULL;
		end else begin
			lvl_w = {1'b0, quo_q};
		end
	end

	assign fresh_w   = has_sample_q && (age_q < FRESH_LIMIT);
	assign snap_w    = relay_q;
	assign min10_w   = {4'b0, min_q} * 11'd10;
	assign max10_w   = {4'b0, max_q} * 11'd10;
	assign lvl_cmp_w = {1'b0, level_n[9:0]};

	always_comb begin
		relay_n  = relay_q;
		status_n = run_status_q;
		level_n  = level_q;
		rt_n     = runtime_q;
		was_n    = was_online_q;
		lock_n   = lock_q;
		fresh_n  = 1'b0;
		unique case (cmd_q)
			CMD_TICK: begin
				fresh_n = fresh_w;
				level_n = fresh_w ? lvl_w : LEVEL_INVALID;
				if (snap_w) begin
					rt_n = (runtime_q == RUN_SAT) ? runtime_q : runtime_q + 17'd1;
				end else begin
					rt_n = '0;
				end
				if (snap_w && (rt_n >= max_rt_q)) begin
					relay_n  = 1'b0;
					status_n = STAT_TIMEOUT;
				end else begin
					if (!online_q && was_online_q) begin
						was_n  = 1'b0;
						lock_n = 1'b0;
					end else if (online_q && !was_online_q) begin
						was_n = 1'b1;
					end
					if (auto_q && (age_q > LOST_LIMIT) && snap_w) begin
						relay_n  = 1'b0;
						status_n = STAT_LOST;
					end else begin
						// An automatic switch replaces any held node lost status.
						if (auto_q && !lock_n && (run_status_q != STAT_TIMEOUT)
								&& !level_n[10]) begin
							if ((lvl_cmp_w <= min10_w) && !snap_w) begin
								relay_n  = 1'b1;
								status_n = STAT_RUN;
							end
							if ((lvl_cmp_w >= max10_w) && snap_w) begin
								relay_n  = 1'b0;
								status_n = STAT_IDLE;
							end
						end
						// Status follows the old relay; off keeps timeout or lost.
						if (snap_w) begin
							status_n = STAT_RUN;
						end else if ((status_n != STAT_TIMEOUT)
								&& (status_n != STAT_LOST)) begin
							status_n = STAT_IDLE;
						end
					end
				end
			end
			CMD_SET: begin
				if (!(lock_q && value_q)) begin
					relay_n  = value_q;
					status_n = value_q ? STAT_RUN : STAT_IDLE;
				end
			end
			CMD_BUTTON: begin
				if (!(online_q && auto_q) && !lock_q) relay_n = !relay_q;
			end
			CMD_CLEAR: begin
				status_n = STAT_IDLE;
				rt_n     = '0;
			end
			CMD_LOCK: lock_n = value_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q      <= 1'b0;
			run_status_q <= STAT_IDLE;
			level_q      <= '0;
			runtime_q    <= '0;
			was_online_q <= 1'b1;
			lock_q       <= 1'b0;
		end else if (cmd.apply) begin
			relay_q      <= relay_n;
			run_status_q <= status_n;
			level_q      <= level_n;
			runtime_q    <= rt_n;
			was_online_q <= was_n;
			lock_q       <= lock_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			o_pump_q    <= relay_n;
			o_status_q  <= status_n;
			o_level_q   <= level_n;
			o_runtime_q <= rt_n;
			o_lock_q    <= lock_n;
			o_fresh_q   <= fresh_n;
		end
	end

	assign pump_on          = o_pump_q;
	assign status           = o_status_q;
	assign level_tenths_pct = o_level_q;
	assign runtime_sec      = o_runtime_q;
	assign lock_active      = o_lock_q;
	assign sample_fresh     = o_fresh_q;

endmodule
